// ===== src/fpu_pkg.sv =====
// fpu_pkg: shared types and constants of the binary16/binary32 arithmetic unit
`timescale 1ns / 1ps
package fpu_pkg;

   typedef logic signed [11:0] exp_type;

   typedef enum logic [1:0] {
      FUNC_ADD = 2'd0,
      FUNC_SUB = 2'd1,
      FUNC_MUL = 2'd2,
      FUNC_DIV = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      RM_RTZ = 2'd0,
      RM_RNE = 2'd1,
      RM_RUP = 2'd2,
      RM_RDN = 2'd3
   } rmode_type;

   localparam logic CSR_FMT   = 1'b0;
   localparam logic CSR_RMODE = 1'b1;

   localparam logic FMT_HALF   = 1'b0;
   localparam logic FMT_SINGLE = 1'b1;

   localparam logic [1:0] RMODE_RESET = 2'd1;
   localparam logic       FMT_RESET   = 1'b1;

   // radix-2 quotient steps: mantissa bits + 4
   localparam logic [4:0] DIV_STEPS_SINGLE = 5'd27;
   localparam logic [4:0] DIV_STEPS_HALF   = 5'd14;

   localparam int MW = 54;  // working mantissa width, normalized to the top bit

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DEC,
      ST_ADD,
      ST_MUL,
      ST_PREP,
      ST_DINIT,
      ST_DIV,
      ST_DFIN,
      ST_NORM,
      ST_ALIGN,
      ST_RND,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic cap;
      logic dec;
      logic add;
      logic mul;
      logic prep;
      logic dinit;
      logic dstep;
      logic dfin;
      logic norm;
      logic align;
      logic rnd;
      logic out;
   } cmd_type;

   typedef struct packed {
      logic     special;
      func_type op;
      logic     add_zero;
      logic     prep_done;
      logic     norm_done;
      logic     out_free;
   } status_type;

endpackage

// ===== src/fpu_ctrl.sv =====
// fpu_ctrl: sequencing state machine of the arithmetic unit
`timescale 1ns / 1ps
module fpu_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                fmt,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  fpu_pkg::status_type status,
   output fpu_pkg::cmd_type    cmd
);

   fpu_pkg::state_type state_ff, state_in;
   logic [4:0] cnt_ff, cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fpu_pkg::ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         fpu_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.cap  = 1'b1;
               state_in = fpu_pkg::ST_DEC;
            end
         end
         fpu_pkg::ST_DEC: begin
            cmd.dec = 1'b1;
            if (status.special) begin
               state_in = fpu_pkg::ST_DONE;
            end else begin
               case (status.op)
                  fpu_pkg::FUNC_MUL: state_in = fpu_pkg::ST_MUL;
                  fpu_pkg::FUNC_DIV: state_in = fpu_pkg::ST_PREP;
                  default:           state_in = fpu_pkg::ST_ADD;
               endcase
            end
         end
         fpu_pkg::ST_ADD: begin
            cmd.add  = 1'b1;
            state_in = status.add_zero ? fpu_pkg::ST_DONE : fpu_pkg::ST_NORM;
         end
         fpu_pkg::ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = fpu_pkg::ST_NORM;
         end
         fpu_pkg::ST_PREP: begin
            cmd.prep = 1'b1;
            if (status.prep_done) state_in = fpu_pkg::ST_DINIT;
         end
         fpu_pkg::ST_DINIT: begin
            cmd.dinit = 1'b1;
            cnt_in    = (fmt == fpu_pkg::FMT_SINGLE) ? fpu_pkg::DIV_STEPS_SINGLE - 5'd1
                                                     : fpu_pkg::DIV_STEPS_HALF - 5'd1;
            state_in  = fpu_pkg::ST_DIV;
         end
         fpu_pkg::ST_DIV: begin
            cmd.dstep = 1'b1;
            if (cnt_ff == '0) state_in = fpu_pkg::ST_DFIN;
            else cnt_in = cnt_ff - 5'd1;
         end
         fpu_pkg::ST_DFIN: begin
            cmd.dfin = 1'b1;
            state_in = fpu_pkg::ST_NORM;
         end
         fpu_pkg::ST_NORM: begin
            cmd.norm = 1'b1;
            if (status.norm_done) state_in = fpu_pkg::ST_ALIGN;
         end
         fpu_pkg::ST_ALIGN: begin
            cmd.align = 1'b1;
            state_in  = fpu_pkg::ST_RND;
         end
         fpu_pkg::ST_RND: begin
            cmd.rnd  = 1'b1;
            state_in = fpu_pkg::ST_DONE;
         end
         fpu_pkg::ST_DONE: begin
            if (status.out_free) begin
               cmd.out  = 1'b1;
               state_in = fpu_pkg::ST_IDLE;
            end
         end
         default: state_in = fpu_pkg::ST_IDLE;
      endcase
   end

endmodule

// ===== src/fpu_dp.sv =====
// fpu_dp: operand decode, add/mul/divide datapath, normalization and rounding
`timescale 1ns / 1ps
module fpu_dp (
   input  logic                clock,
   input  logic                reset,
   input  logic                fmt,
   input  logic [1:0]          round_mode,
   input  logic [63:0]         req_tdata,
   input  logic [1:0]          req_tuser,
   input  fpu_pkg::cmd_type    cmd,
   output fpu_pkg::status_type status,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [31:0]         rsp_tdata
);

   typedef struct packed {
      logic             s;
      logic             zero;
      logic             inf;
      logic             nan;
      logic [23:0]      m;
      fpu_pkg::exp_type q;
   } opnd_type;

   function automatic opnd_type unpack(input logic [31:0] v, input logic f);
      opnd_type         o;
      logic [7:0]       e;
      logic [22:0]      fr;
      logic [7:0]       emax;
      fpu_pkg::exp_type ee;
      if (f == fpu_pkg::FMT_SINGLE) begin
         o.s  = v[31];
         e    = v[30:23];
         fr   = v[22:0];
         emax = 8'hff;
      end else begin
         o.s  = v[15];
         e    = {3'b0, v[14:10]};
         fr   = {13'b0, v[9:0]};
         emax = 8'h1f;
      end
      o.nan  = (e == emax) && (fr != '0);
      o.inf  = (e == emax) && (fr == '0);
      o.zero = (e == '0) && (fr == '0);
      if (f == fpu_pkg::FMT_SINGLE) o.m = {e != '0, fr};
      else o.m = {13'b0, e != '0, fr[9:0]};
      ee  = (e == '0) ? 12'sd1 : fpu_pkg::exp_type'({4'b0, e});
      o.q = (f == fpu_pkg::FMT_SINGLE) ? ee - 12'sd150 : ee - 12'sd25;
      return o;
   endfunction

   logic [31:0] a_ff, b_ff;
   logic [1:0]  func_ff;
   logic [23:0] ma_ff, mb_ff;
   fpu_pkg::exp_type qa_ff, qb_ff, q_ff, lsbe_ff;
   logic        sa_ff, sb_ff, s_ff;
   logic [fpu_pkg::MW-1:0] m_ff;
   logic        sticky_ff, rbit_ff;
   logic [25:0] rem_ff;
   logic [26:0] quo_ff;
   logic [24:0] kept_ff;
   logic [31:0] res_ff;
   logic        rsp_valid_ff;
   logic [31:0] rsp_data_ff;

   // format dependent values
   logic [31:0]      sbit, nan_val;
   fpu_pkg::exp_type mbits, bias_v, emax_v;
   always_comb begin
      if (fmt == fpu_pkg::FMT_SINGLE) begin
         sbit    = 32'h8000_0000;
         nan_val = 32'hff80_0001;
         mbits   = 12'sd23;
         bias_v  = 12'sd127;
         emax_v  = 12'sd255;
      end else begin
         sbit    = 32'h0000_8000;
         nan_val = 32'h0000_fc01;
         mbits   = 12'sd10;
         bias_v  = 12'sd15;
         emax_v  = 12'sd31;
      end
   end

   function automatic logic [31:0] inf_of(input logic s, input logic f);
      logic [31:0] r;
      if (f == fpu_pkg::FMT_SINGLE) r = {s, 8'hff, 23'b0};
      else r = {16'b0, s, 5'h1f, 10'b0};
      return r;
   endfunction

   // decode and special cases
   opnd_type    da, db;
   logic [31:0] av, bv, spec_val;
   logic        spec;
   always_comb begin
      av = (fmt == fpu_pkg::FMT_SINGLE) ? a_ff : {16'b0, a_ff[15:0]};
      bv = (fmt == fpu_pkg::FMT_SINGLE) ? b_ff : {16'b0, b_ff[15:0]};
      da = unpack(av, fmt);
      db = unpack(bv, fmt);
      spec     = 1'b1;
      spec_val = nan_val;
      if (da.nan || db.nan) begin
         spec_val = nan_val;
      end else begin
         case (func_ff)
            fpu_pkg::FUNC_ADD, fpu_pkg::FUNC_SUB: begin
               if (func_ff == fpu_pkg::FUNC_SUB) begin
                  bv   = bv ^ sbit;
                  db.s = ~db.s;
               end
               if (da.inf && db.inf && (da.s != db.s)) spec_val = nan_val;
               else if (da.inf) spec_val = av;
               else if (db.inf) spec_val = bv;
               else if (da.zero && db.zero) spec_val = (da.s & db.s) ? sbit : '0;
               else if (da.zero) spec_val = bv;
               else if (db.zero) spec_val = av;
               else spec = 1'b0;
            end
            fpu_pkg::FUNC_MUL: begin
               if ((da.zero && db.inf) || (db.zero && da.inf)) spec_val = nan_val;
               else if (da.inf || db.inf) spec_val = inf_of(da.s ^ db.s, fmt);
               else if (da.zero || db.zero) spec_val = (da.s ^ db.s) ? sbit : '0;
               else spec = 1'b0;
            end
            default: begin
               if ((da.inf && db.inf) || (da.zero && db.zero)) spec_val = nan_val;
               else if (db.inf || da.zero) spec_val = (da.s ^ db.s) ? sbit : '0;
               else if (db.zero || da.inf) spec_val = inf_of(da.s ^ db.s, fmt);
               else spec = 1'b0;
            end
         endcase
      end
   end

   // alignment add, larger magnitude first
   logic        swap;
   logic [23:0] mbig, msml;
   fpu_pkg::exp_type qbig, qsml, dd;
   logic [fpu_pkg::MW-1:0] xs, ys, sum;
   always_comb begin
      swap = (qa_ff < qb_ff) || ((qa_ff == qb_ff) && (ma_ff < mb_ff));
      mbig = swap ? mb_ff : ma_ff;
      msml = swap ? ma_ff : mb_ff;
      qbig = swap ? qb_ff : qa_ff;
      qsml = swap ? qa_ff : qb_ff;
      dd   = qbig - qsml;
      if (dd > mbits + 12'sd4) begin
         // far smaller operand only contributes a sticky one
         dd   = mbits + 12'sd5;
         msml = 24'd1;
         qsml = qbig - dd;
      end
      xs  = (fpu_pkg::MW)'(mbig) << dd[4:0];
      ys  = (fpu_pkg::MW)'(msml);
      sum = ((swap ? sb_ff : sa_ff) == (swap ? sa_ff : sb_ff)) ? xs + ys : xs - ys;
   end

   logic [47:0] prod;
   assign prod = ma_ff * mb_ff;

   // restoring division step
   logic [26:0] ddiff;
   logic        dge;
   logic [25:0] nrem;
   always_comb begin
      ddiff = {1'b0, rem_ff} - {3'b0, mb_ff};
      dge   = ~ddiff[26];
      nrem  = dge ? ddiff[25:0] : rem_ff;
   end

   // right alignment to the result grid with guard and sticky
   fpu_pkg::exp_type e_v, emin_v, lsbe_v, sh_v;
   logic [5:0]  shc;
   logic [63:0] m64, kept64, lmask;
   always_comb begin
      e_v    = q_ff + fpu_pkg::exp_type'(fpu_pkg::MW - 1);
      emin_v = 12'sd1 - bias_v;
      lsbe_v = ((e_v > emin_v) ? e_v : emin_v) - mbits;
      sh_v   = lsbe_v - q_ff;
      shc    = (sh_v > 12'sd63) ? 6'd63 : sh_v[5:0];
      m64    = 64'(m_ff);
      kept64 = m64 >> shc;
      lmask  = (64'd1 << (shc - 6'd1)) - 64'd1;
   end

   // rounding and packing
   logic        inc, ovb, nrm;
   logic [24:0] k2, k3;
   fpu_pkg::exp_type lsbe2, field;
   logic [31:0] rnd_val;
   always_comb begin
      case (round_mode)
         fpu_pkg::RM_RNE: inc = rbit_ff && (sticky_ff || kept_ff[0]);
         fpu_pkg::RM_RUP: inc = !s_ff && (rbit_ff || sticky_ff);
         fpu_pkg::RM_RDN: inc = s_ff && (rbit_ff || sticky_ff);
         default:         inc = 1'b0;
      endcase
      k2    = kept_ff + {24'b0, inc};
      ovb   = (fmt == fpu_pkg::FMT_SINGLE) ? k2[24] : k2[11];
      k3    = ovb ? (k2 >> 1) : k2;
      lsbe2 = lsbe_ff + (ovb ? 12'sd1 : 12'sd0);
      nrm   = (fmt == fpu_pkg::FMT_SINGLE) ? k3[23] : k3[10];
      field = nrm ? lsbe2 + mbits + bias_v : 12'sd0;
      if (k3 == '0) begin
         rnd_val = s_ff ? sbit : '0;
      end else if (field >= emax_v) begin
         if ((round_mode == fpu_pkg::RM_RNE) || (round_mode == fpu_pkg::RM_RUP && !s_ff)
             || (round_mode == fpu_pkg::RM_RDN && s_ff))
            rnd_val = inf_of(s_ff, fmt);
         else
            rnd_val = inf_of(s_ff, fmt) - 32'd1;
      end else if (fmt == fpu_pkg::FMT_SINGLE) begin
         rnd_val = {s_ff, field[7:0], k3[22:0]};
      end else begin
         rnd_val = {16'b0, s_ff, field[4:0], k3[9:0]};
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.cap) begin
         a_ff    <= req_tdata[31:0];
         b_ff    <= req_tdata[63:32];
         func_ff <= req_tuser;
      end
      if (cmd.dec) begin
         res_ff <= spec_val;
         ma_ff  <= da.m;
         mb_ff  <= db.m;
         qa_ff  <= da.q;
         qb_ff  <= db.q;
         sa_ff  <= da.s;
         sb_ff  <= db.s;
         s_ff   <= da.s ^ db.s;
      end
      if (cmd.add) begin
         m_ff      <= sum;
         q_ff      <= qsml;
         s_ff      <= swap ? sb_ff : sa_ff;
         sticky_ff <= 1'b0;
         res_ff    <= '0;
      end
      if (cmd.mul) begin
         m_ff      <= (fpu_pkg::MW)'(prod);
         q_ff      <= qa_ff + qb_ff;
         sticky_ff <= 1'b0;
      end
      if (cmd.prep) begin
         if (!ma_ff[23]) begin
            ma_ff <= ma_ff << 1;
            qa_ff <= qa_ff - 12'sd1;
         end
         if (!mb_ff[23]) begin
            mb_ff <= mb_ff << 1;
            qb_ff <= qb_ff - 12'sd1;
         end
      end
      if (cmd.dinit) begin
         rem_ff <= {2'b0, ma_ff};
         quo_ff <= '0;
      end
      if (cmd.dstep) begin
         quo_ff    <= {quo_ff[25:0], dge};
         rem_ff    <= {nrem[24:0], 1'b0};
         sticky_ff <= nrem != '0;
      end
      if (cmd.dfin) begin
         m_ff <= (fpu_pkg::MW)'(quo_ff);
         q_ff <= qa_ff - qb_ff - mbits - 12'sd3;
      end
      if (cmd.norm && !m_ff[fpu_pkg::MW-1]) begin
         if (m_ff[fpu_pkg::MW-1 -: 8] == '0) begin
            m_ff <= m_ff << 8;
            q_ff <= q_ff - 12'sd8;
         end else begin
            m_ff <= m_ff << 1;
            q_ff <= q_ff - 12'sd1;
         end
      end
      if (cmd.align) begin
         kept_ff   <= kept64[24:0];
         rbit_ff   <= m64[shc - 6'd1];
         sticky_ff <= sticky_ff | ((m64 & lmask) != '0);
         lsbe_ff   <= lsbe_v;
      end
      if (cmd.rnd) res_ff <= rnd_val;
      if (cmd.out) rsp_data_ff <= res_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (cmd.out) rsp_valid_ff <= 1'b1;
      else if (rsp_tready) rsp_valid_ff <= 1'b0;
   end

   always_comb begin
      status.special   = spec;
      status.op        = fpu_pkg::func_type'(func_ff);
      status.add_zero  = sum == '0;
      status.prep_done = ma_ff[23] && mb_ff[23];
      status.norm_done = m_ff[fpu_pkg::MW-1];
      status.out_free  = !rsp_valid_ff || rsp_tready;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ===== src/fp_add_sub_mul_div_unit_core.sv =====
// fp_add_sub_mul_div_unit_core: top level of the binary16/binary32 arithmetic unit
`timescale 1ns / 1ps
// Works on one item at a time. Special operands (NaN, infinity, zero) and an
// exact cancellation go straight to the result. Add, subtract and multiply
// normalize, which shifts the result up to the top of a 54-bit register
// eight bits per cycle while its top byte is clear and one bit per cycle after
// that. Divide first shifts both mantissas up to bit 23 one bit per cycle, then
// runs 27 (binary32) or 14 (binary16) radix-2 restoring quotient steps and
// normalizes. A stalled rsp_tready holds the result and the unit; a new item is
// taken in the idle state entered after the previous result is loaded into the
// output register.
module fp_add_sub_mul_div_unit_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // operand_a [31:0], operand_b [63:32]
   input  logic [1:0]  req_tuser,   // func [1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // result_bits [31:0]
   input  logic        csr_we,
   input  logic        csr_addr,
   input  logic [1:0]  csr_wdata
);

   logic                fmt_ff;
   logic [1:0]          rmode_ff;
   fpu_pkg::cmd_type    cmd;
   fpu_pkg::status_type status;

   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff   <= fpu_pkg::FMT_RESET;
         rmode_ff <= fpu_pkg::RMODE_RESET;
      end else if (csr_we) begin
         if (csr_addr == fpu_pkg::CSR_FMT) fmt_ff <= csr_wdata[0];
         else rmode_ff <= csr_wdata;
      end
   end

   fpu_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .fmt        (fmt_ff),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   fpu_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .fmt        (fmt_ff),
      .round_mode (rmode_ff),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cmd        (cmd),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

`ifndef ASSERT_OFF
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input taken again right after accept");

   a_half_upper_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (fmt_ff == fpu_pkg::FMT_HALF) |-> rsp_tdata[31:16] == '0)
      else $error("binary16 result has upper bits set");

   a_result_needs_item: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> !req_tready || $past(cmd.out))
      else $error("result without work");
`endif

endmodule

// ===== dv/tb_fp_add_sub_mul_div_unit_core.sv =====
// testbench for the binary16/binary32 add, subtract, multiply and divide unit
`timescale 1ns / 1ps
module tb_fp_add_sub_mul_div_unit_core;

   class fp_result_board;
      logic [31:0]        result_q[$];
      logic               fmt_sel;
      fpu_pkg::rmode_type rmode;
      int                 errors;

      function new();
         fmt_sel = fpu_pkg::FMT_RESET;
         rmode   = fpu_pkg::rmode_type'(fpu_pkg::RMODE_RESET);
         errors  = 0;
      endfunction

      function logic [63:0] special_bits(int ebits, int mbits, int total, bit s);
         return ({63'd0, s} << (total - 1)) | (((64'd1 << ebits) - 1) << mbits);
      endfunction

      function logic [63:0] round_pack(int mbits, int ebits, int bias, int total, bit s,
                                       logic [63:0] m, int q, bit sticky);
         int          tb, e, emin, lsbe, sh, field;
         logic [63:0] kept, low;
         bit          rbit, st, inc;
         tb = 0;
         for (int i = 0; i < 64; i++) if (m[i]) tb = i;
         e    = tb + q;
         emin = 1 - bias;
         lsbe = ((e > emin) ? e : emin) - mbits;
         sh   = lsbe - q;
         rbit = 0;
         st   = sticky;
         inc  = 0;
         if (sh <= 0) begin
            kept = m << (-sh);
         end else begin
            kept = (sh < 64) ? (m >> sh) : 64'd0;
            if (sh - 1 < 64) begin
               rbit = m[sh - 1];
               low  = m & ((64'd1 << (sh - 1)) - 1);
            end else begin
               low = m;
            end
            if (low != 0) st = 1;
         end
         case (rmode)
            fpu_pkg::RM_RNE: inc = rbit && (st || kept[0]);
            fpu_pkg::RM_RUP: inc = !s && (rbit || st);
            fpu_pkg::RM_RDN: inc = s && (rbit || st);
            default: inc = 0;
         endcase
         if (inc) kept++;
         if ((kept >> (mbits + 1)) != 0) begin
            kept = kept >> 1;
            lsbe++;
         end
         if (kept == 0) return {63'd0, s} << (total - 1);
         field = (kept < (64'd1 << mbits)) ? 0 : lsbe + mbits + bias;
         if (field >= (1 << ebits) - 1) begin
            // overflow: infinity unless the mode rounds away from it
            if (rmode == fpu_pkg::RM_RNE || (rmode == fpu_pkg::RM_RUP && !s)
                || (rmode == fpu_pkg::RM_RDN && s))
               return special_bits(ebits, mbits, total, s);
            return special_bits(ebits, mbits, total, s) - 1;
         end
         return ({63'd0, s} << (total - 1)) | (64'(field) << mbits)
                | (kept & ((64'd1 << mbits) - 1));
      endfunction

      function logic [31:0] predict(logic [31:0] a_in, logic [31:0] b_in,
                                    fpu_pkg::func_type fn);
         int          mbits, ebits, bias, total, emaxv, ea, eb, qa, qb, d, extra, tq;
         logic [63:0] av, bv, mask, mmask, ma, mb, tm, num, quo, rem, r, nan_v;
         longint      x, y, sum;
         bit          sa, sb, s, ts, nan_a, nan_b, inf_a, inf_b, zero_a, zero_b;
         fpu_pkg::func_type op;
         if (fmt_sel == fpu_pkg::FMT_SINGLE) begin
            mbits = 23; ebits = 8; bias = 127; total = 32;
         end else begin
            mbits = 10; ebits = 5; bias = 15; total = 16;
         end
         mask   = (total == 32) ? 64'hFFFF_FFFF : 64'hFFFF;
         av     = {32'd0, a_in} & mask;
         bv     = {32'd0, b_in} & mask;
         mmask  = (64'd1 << mbits) - 1;
         emaxv  = (1 << ebits) - 1;
         sa     = av[total - 1];
         sb     = bv[total - 1];
         ea     = int'((av >> mbits) & emaxv);
         eb     = int'((bv >> mbits) & emaxv);
         ma     = av & mmask;
         mb     = bv & mmask;
         nan_a  = (ea == emaxv) && (ma != 0);
         nan_b  = (eb == emaxv) && (mb != 0);
         inf_a  = (ea == emaxv) && (ma == 0);
         inf_b  = (eb == emaxv) && (mb == 0);
         zero_a = (ea == 0) && (ma == 0);
         zero_b = (eb == 0) && (mb == 0);
         s      = sa ^ sb;
         op     = fn;
         nan_v  = special_bits(ebits, mbits, total, 1'b1) | 64'd1;
         if (nan_a || nan_b) return nan_v[31:0];
         if (op == fpu_pkg::FUNC_SUB) begin
            sb = !sb;
            bv = bv ^ (64'd1 << (total - 1));
            op = fpu_pkg::FUNC_ADD;
         end
         qa = ((ea == 0) ? 1 : ea) - bias - mbits;
         qb = ((eb == 0) ? 1 : eb) - bias - mbits;
         if (ea != 0) ma = ma | (64'd1 << mbits);
         if (eb != 0) mb = mb | (64'd1 << mbits);
         if (op == fpu_pkg::FUNC_ADD) begin
            if (inf_a && inf_b && sa != sb) r = nan_v;
            else if (inf_a) r = av;
            else if (inf_b) r = bv;
            else if (zero_a && zero_b) r = (sa && sb) ? (64'd1 << (total - 1)) : 64'd0;
            else if (zero_a) r = bv;
            else if (zero_b) r = av;
            else begin
               if (qa < qb || (qa == qb && ma < mb)) begin
                  tm = ma; tq = qa; ts = sa;
                  ma = mb; qa = qb; sa = sb;
                  mb = tm; qb = tq; sb = ts;
               end
               d = qa - qb;
               // far smaller addend only contributes a sticky bit
               if (d > mbits + 4) begin
                  d  = mbits + 5;
                  mb = 64'd1;
                  qb = qa - d;
               end
               x   = longint'(ma << d);
               y   = longint'(mb);
               sum = (sa == sb) ? x + y : x - y;
               if (sum == 0) r = 64'd0;
               else r = round_pack(mbits, ebits, bias, total, sa, 64'(sum), qb, 0);
            end
         end else if (op == fpu_pkg::FUNC_MUL) begin
            if ((zero_a && inf_b) || (zero_b && inf_a)) r = nan_v;
            else if (inf_a || inf_b) r = special_bits(ebits, mbits, total, s);
            else if (zero_a || zero_b) r = {63'd0, s} << (total - 1);
            else r = round_pack(mbits, ebits, bias, total, s, ma * mb, qa + qb, 0);
         end else begin
            if ((inf_a && inf_b) || (zero_a && zero_b)) r = nan_v;
            else if (inf_b || zero_a) r = {63'd0, s} << (total - 1);
            else if (zero_b || inf_a) r = special_bits(ebits, mbits, total, s);
            else begin
               extra = mbits + 3;
               while ((ma >> mbits) == 0) begin ma = ma << 1; qa--; end
               while ((mb >> mbits) == 0) begin mb = mb << 1; qb--; end
               num = ma << extra;
               quo = num / mb;
               rem = num - quo * mb;
               r = round_pack(mbits, ebits, bias, total, s, quo, qa - qb - extra,
                              rem != 0);
            end
         end
         r = r & mask;
         return r[31:0];
      endfunction

      function void note_input(logic [31:0] a_in, logic [31:0] b_in,
                               fpu_pkg::func_type fn);
         result_q.push_back(predict(a_in, b_in, fn));
      endfunction

      function void check_result(logic [31:0] actual);
         logic [31:0] want;
         if (result_q.size() == 0) begin
            $display("%0t: unexpected result beat, expected none actual %h", $time, actual);
            errors++;
         end else begin
            want = result_q.pop_front();
            if (want !== actual) begin
               $display("%0t: result_bits mismatch, expected %h actual %h",
                        $time, want, actual);
               errors++;
            end
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [63:0] req_tdata;
   logic [1:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;
   logic        csr_we;
   logic        csr_addr;
   logic [1:0]  csr_wdata;

   fp_result_board board;
   bit             idle_on;
   int             cycle_count;

   localparam int CYCLE_LIMIT = 600000;

   fp_add_sub_mul_div_unit_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready)
         board.note_input(req_tdata[31:0], req_tdata[63:32],
                          fpu_pkg::func_type'(req_tuser));
      if (!reset && rsp_tvalid && rsp_tready)
         board.check_result(rsp_tdata);
   end

   // result side stalls in bursts
   initial begin
      rsp_tready = 1'b1;
      forever begin
         @(negedge clock);
         if (idle_on && $urandom_range(0, 5) == 0) begin
            rsp_tready = 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge clock);
            rsp_tready = 1'b1;
         end
      end
   end

   task automatic send_op(logic [31:0] a_in, logic [31:0] b_in, fpu_pkg::func_type fn);
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_tvalid = 1'b0;
         repeat ($urandom_range(1, 9)) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = {b_in, a_in};
      req_tuser  = fn;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic write_csr(logic addr, logic [1:0] value);
      req_tvalid = 1'b0;
      while (board.result_q.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      csr_we    = 1'b1;
      csr_addr  = addr;
      csr_wdata = value;
      @(negedge clock);
      csr_we = 1'b0;
      if (addr == fpu_pkg::CSR_FMT) board.fmt_sel = value[0];
      else board.rmode = fpu_pkg::rmode_type'(value);
   endtask

   // value of a given class in the current format, upper half random in binary16
   function automatic logic [31:0] pick_value(bit single, int kind);
      logic [31:0] v;
      bit          sg;
      sg = $urandom_range(0, 1);
      if (single) begin
         case (kind)
            0: v = {sg, 31'd0};
            1: v = {sg, 8'hFF, 23'd0};
            2: v = {$urandom_range(0, 1) == 1, 8'hFF, 23'($urandom_range(1, 32'h7FFFFF))};
            3: v = {sg, 8'd0, 23'($urandom_range(1, 32'h7FFFFF))};
            4: v = {sg, 8'hFE, 23'h7FFFFF};
            5: v = {sg, 8'd0, 23'd1};
            6: v = {sg, 8'($urandom_range(120, 134)), 23'($urandom)};
            7: v = {sg, 8'($urandom_range(1, 24)), 23'($urandom)};
            8: v = {sg, 8'($urandom_range(230, 254)), 23'($urandom)};
            default: v = $urandom;
         endcase
      end else begin
         case (kind)
            0: v[15:0] = {sg, 15'd0};
            1: v[15:0] = {sg, 5'h1F, 10'd0};
            2: v[15:0] = {$urandom_range(0, 1) == 1, 5'h1F, 10'($urandom_range(1, 1023))};
            3: v[15:0] = {sg, 5'd0, 10'($urandom_range(1, 1023))};
            4: v[15:0] = {sg, 5'h1E, 10'h3FF};
            5: v[15:0] = {sg, 5'd0, 10'd1};
            6: v[15:0] = {sg, 5'($urandom_range(12, 18)), 10'($urandom)};
            7: v[15:0] = {sg, 5'($urandom_range(1, 5)), 10'($urandom)};
            8: v[15:0] = {sg, 5'($urandom_range(25, 30)), 10'($urandom)};
            default: v[15:0] = 16'($urandom);
         endcase
         v[31:16] = 16'($urandom);
      end
      return v;
   endfunction

   task automatic run_directed(bit single);
      logic [31:0] one, mone, inf, ninf, pz, nz, big, tiny, qnan;
      logic [31:0] hi;
      hi   = single ? 32'd0 : 32'hFFFF_0000;
      one  = single ? 32'h3F80_0000 : (hi | 32'h3C00);
      mone = single ? 32'hBF80_0000 : (hi | 32'hBC00);
      inf  = single ? 32'h7F80_0000 : (hi | 32'h7C00);
      ninf = single ? 32'hFF80_0000 : (hi | 32'hFC00);
      pz   = hi;
      nz   = single ? 32'h8000_0000 : (hi | 32'h8000);
      big  = single ? 32'h7F7F_FFFF : (hi | 32'h7BFF);
      tiny = single ? 32'h0000_0001 : (hi | 32'h0001);
      qnan = single ? 32'h7FC0_0000 : (hi | 32'h7E00);
      send_op(big, big, fpu_pkg::FUNC_ADD);
      send_op(one, mone, fpu_pkg::FUNC_ADD);
      send_op(inf, ninf, fpu_pkg::FUNC_ADD);
      send_op(one, one, fpu_pkg::FUNC_SUB);
      send_op(nz, pz, fpu_pkg::FUNC_SUB);
      send_op(qnan, one, fpu_pkg::FUNC_SUB);
      send_op(pz, inf, fpu_pkg::FUNC_MUL);
      send_op(tiny, tiny, fpu_pkg::FUNC_MUL);
      send_op(32'hFFFF_FFFF, 32'h7FFF_FFFF, fpu_pkg::FUNC_MUL);
      send_op(mone, pz, fpu_pkg::FUNC_DIV);
      send_op(pz, nz, fpu_pkg::FUNC_DIV);
      send_op(inf, ninf, fpu_pkg::FUNC_DIV);
   endtask

   initial begin
      logic [31:0] a_v, b_v;
      bit          single;
      int          n_phase;
      board       = new();
      cycle_count = 0;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = '0;
      csr_we      = 1'b0;
      csr_addr    = fpu_pkg::CSR_FMT;
      csr_wdata   = '0;
      idle_on     = 1'b1;
      repeat (5) @(negedge clock);
      reset = 1'b0;
      for (int p = 0; p < 8; p++) begin
         single = p[0];
         write_csr(fpu_pkg::CSR_FMT, {1'b0, single});
         write_csr(fpu_pkg::CSR_RMODE, 2'(p >> 1));
         if (p < 2) run_directed(single);
         n_phase = 160;
         if (p == 7) idle_on = 1'b0;
         for (int i = 0; i < n_phase; i++) begin
            a_v = pick_value(single, $urandom_range(0, 15));
            case ($urandom_range(0, 7))
               0: b_v = a_v;
               1: b_v = single ? (a_v ^ 32'h8000_0000) : (a_v ^ 32'h0000_8000);
               2: b_v = a_v + $urandom_range(0, 3) - 2;
               default: b_v = pick_value(single, $urandom_range(0, 15));
            endcase
            send_op(a_v, b_v, fpu_pkg::func_type'($urandom_range(0, 3)));
         end
      end
      req_tvalid = 1'b0;
      while (board.result_q.size() != 0) @(negedge clock);
      repeat (60) @(negedge clock);
      if (board.errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
